### hw/rtl/skfs_pkg.sv
// Shared widths and controller state type for the sorted key floor search.
package skfs_pkg;

  localparam int IDX_W   = 10;  // width of a table index on the ports
  localparam int KEY_W   = 64;  // width of a table key
  localparam int FOUND_W = 11;  // signed result index, -1 .. 1023
  localparam int BOUND_W = 12;  // signed search bounds, -1 .. 1024

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_COMPARE
  } state_t;

endpackage

### hw/rtl/skfs_key_ram.sv
// Key table: single write port, single registered read port.
module skfs_key_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [skfs_pkg::KEY_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [skfs_pkg::KEY_W-1:0] rd_data
);

  logic [skfs_pkg::KEY_W-1:0] mem [DEPTH];
  logic [skfs_pkg::KEY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/sorted_key_floor_search.sv
// Top level of the sorted key floor search block.

// A write item (in_kind low) stores in_entry_key at in_entry_index and
// gives no result; writes beyond the table depth are dropped. A search item bisects
// the inclusive window [in_first_index, in_last_index] and returns one result,
// strobed by out_valid for a single cycle, which the receiver must take as it
// comes. Each bisection step reads the key table in ST_PROBE and compares in
// ST_COMPARE, and busy stays high throughout a search. Writes and reads of the
// table never overlap, so no forwarding is needed. Searching an entry that was
// never written returns an undefined answer.
module sorted_key_floor_search #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_kind,
  input  logic [skfs_pkg::IDX_W-1:0]          in_entry_index,
  input  logic [skfs_pkg::KEY_W-1:0]          in_entry_key,
  input  logic [skfs_pkg::IDX_W-1:0]          in_first_index,
  input  logic [skfs_pkg::IDX_W-1:0]          in_last_index,
  output logic                                out_valid,
  output logic signed [skfs_pkg::FOUND_W-1:0] out_found_index,
  output logic                                out_exact_match
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int IW = (AW > skfs_pkg::IDX_W) ? AW : skfs_pkg::IDX_W;
  localparam logic [IW:0] DEPTH_C = (IW + 1)'(TABLE_DEPTH);
  localparam int BW = skfs_pkg::BOUND_W;

  skfs_pkg::state_t state_r, state_nxt;

  logic [skfs_pkg::KEY_W-1:0]          key_r, key_nxt;
  logic signed [BW-1:0]                lo_r, lo_nxt;
  logic signed [BW-1:0]                hi_r, hi_nxt;
  logic [skfs_pkg::IDX_W-1:0]          mid_r, mid_nxt;
  logic                                in_range_r, in_range_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic signed [skfs_pkg::FOUND_W-1:0] out_found_r, out_found_nxt;
  logic                                out_exact_r, out_exact_nxt;

  logic                       accept;
  logic                       window_open;
  logic [BW-1:0]              bound_sum;
  logic [skfs_pkg::IDX_W-1:0] mid_calc;
  logic [IW-1:0]              wr_ext;
  logic [IW-1:0]              rd_ext;
  logic                       wr_en;
  logic                       rd_en;
  logic [skfs_pkg::KEY_W-1:0] rd_data;
  logic [skfs_pkg::KEY_W-1:0] probe_key;

  assign busy   = (state_r != skfs_pkg::ST_IDLE);
  assign accept = start && !busy;

  // Both bounds are non-negative whenever the window is open, so the sum is too.
  assign window_open = (lo_r <= hi_r);
  assign bound_sum   = BW'(lo_r + hi_r);
  assign mid_calc    = bound_sum[skfs_pkg::IDX_W:1];

  assign wr_ext = IW'(in_entry_index);
  assign rd_ext = IW'(mid_calc);
  assign wr_en  = accept && (in_kind == skfs_pkg::KIND_WRITE) && ({1'b0, wr_ext} < DEPTH_C);
  assign rd_en  = (state_r == skfs_pkg::ST_PROBE) && window_open;

  // Probes past the end of the table see a zero key.
  assign probe_key = in_range_r ? rd_data : '0;

  skfs_key_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_ext[AW-1:0]),
    .wr_data (in_entry_key),
    .rd_en   (rd_en),
    .rd_addr (rd_ext[AW-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      skfs_pkg::ST_IDLE: begin
        if (accept && (in_kind == skfs_pkg::KIND_SEARCH)) begin
          state_nxt = skfs_pkg::ST_PROBE;
        end
      end
      skfs_pkg::ST_PROBE: begin
        state_nxt = window_open ? skfs_pkg::ST_COMPARE : skfs_pkg::ST_IDLE;
      end
      skfs_pkg::ST_COMPARE: begin
        state_nxt = (probe_key == key_r) ? skfs_pkg::ST_IDLE : skfs_pkg::ST_PROBE;
      end
      default: begin
        state_nxt = skfs_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    key_nxt       = key_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    in_range_nxt  = in_range_r;
    out_valid_nxt = 1'b0;
    out_found_nxt = out_found_r;
    out_exact_nxt = out_exact_r;
    unique case (state_r)
      skfs_pkg::ST_IDLE: begin
        if (accept && (in_kind == skfs_pkg::KIND_SEARCH)) begin
          key_nxt = in_entry_key;
          lo_nxt  = BW'(in_first_index);
          hi_nxt  = BW'(in_last_index);
        end
      end
      skfs_pkg::ST_PROBE: begin
        if (window_open) begin
          mid_nxt      = mid_calc;
          in_range_nxt = ({1'b0, rd_ext} < DEPTH_C);
        end else begin
          // Nothing matched: hi has settled on the floor entry, or first - 1 (last if the window began empty).
          out_valid_nxt = 1'b1;
          out_found_nxt = hi_r[skfs_pkg::FOUND_W-1:0];
          out_exact_nxt = 1'b0;
        end
      end
      skfs_pkg::ST_COMPARE: begin
        if (probe_key == key_r) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = skfs_pkg::FOUND_W'(mid_r);
          out_exact_nxt = 1'b1;
        end else if (probe_key < key_r) begin
          lo_nxt = BW'(mid_r) + BW'(1);
        end else begin
          hi_nxt = BW'(mid_r) - BW'(1);
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skfs_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    in_range_r  <= in_range_nxt;
    out_found_r <= out_found_nxt;
    out_exact_r <= out_exact_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_found_index = out_found_r;
  assign out_exact_match = out_exact_r;

`ifndef SYNTHESIS
  a_result_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_result_ends_search: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result given while search still running");

  a_search_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_kind == skfs_pkg::KIND_SEARCH)) |=> busy)
    else $error("accepted search did not start");

  a_write_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_kind == skfs_pkg::KIND_WRITE)) |=> !busy && !out_valid)
    else $error("write item caused activity");

  a_exact_non_negative: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_exact_match) |-> !out_found_index[skfs_pkg::FOUND_W-1])
    else $error("exact match reported at a negative index");
`endif

endmodule

### tb/sorted_key_floor_search_tb.sv
// Self-checking testbench for the sorted key floor search block.
`timescale 1ns / 100ps

module sorted_key_floor_search_tb;

  localparam int          DEPTH      = 1024;
  localparam int          RAND_ITEMS = 800;
  localparam int          QUIET_TAIL = 150;
  localparam int          STALL_MAX  = 2000;
  localparam logic [63:0] KEY_MAX    = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic signed [skfs_pkg::FOUND_W-1:0] found;
    logic                                exact;
  } lookup_t;

  typedef struct {
    logic                       kind;
    logic [skfs_pkg::IDX_W-1:0] slot;
    logic [skfs_pkg::KEY_W-1:0] key;
    logic [skfs_pkg::IDX_W-1:0] first;
    logic [skfs_pkg::IDX_W-1:0] last;
    bit                         typed;
    lookup_t                    res;
  } stim_row_t;

  logic                                clk;
  logic                                rst_n;
  logic                                start;
  logic                                busy;
  logic                                in_kind;
  logic [skfs_pkg::IDX_W-1:0]          in_entry_index;
  logic [skfs_pkg::KEY_W-1:0]          in_entry_key;
  logic [skfs_pkg::IDX_W-1:0]          in_first_index;
  logic [skfs_pkg::IDX_W-1:0]          in_last_index;
  logic                                out_valid;
  logic signed [skfs_pkg::FOUND_W-1:0] out_found_index;
  logic                                out_exact_match;

  bit [skfs_pkg::KEY_W-1:0] key_shadow [DEPTH];
  lookup_t                  pending_lookups [$];
  lookup_t                  want;
  int                       fail_count;
  int                       stall_cycles;
  bit                       bursty;
  bit                       quiet;

  sorted_key_floor_search #(.TABLE_DEPTH(DEPTH)) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_entry_index  (in_entry_index),
    .in_entry_key    (in_entry_key),
    .in_first_index  (in_first_index),
    .in_last_index   (in_last_index),
    .out_valid       (out_valid),
    .out_found_index (out_found_index),
    .out_exact_match (out_exact_match)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic logic [skfs_pkg::KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [skfs_pkg::IDX_W-1:0] rand_index();
    logic [31:0] r;
    r = $urandom;
    return r[skfs_pkg::IDX_W-1:0];
  endfunction

  // Bisects the window over the shadow table exactly as the block should.
  function automatic lookup_t floor_lookup(input logic [skfs_pkg::KEY_W-1:0] key,
                                           input logic [skfs_pkg::IDX_W-1:0] first,
                                           input logic [skfs_pkg::IDX_W-1:0] last);
    int      lo;
    int      hi;
    int      mid;
    lookup_t r;
    lo = first;
    hi = last;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (key_shadow[mid] == key) begin
        r.found = mid[skfs_pkg::FOUND_W-1:0];
        r.exact = 1'b1;
        return r;
      end
      if (key_shadow[mid] < key) lo = mid + 1;
      else hi = mid - 1;
    end
    r.found = hi[skfs_pkg::FOUND_W-1:0];
    r.exact = 1'b0;
    return r;
  endfunction

  function automatic stim_row_t dir_row(input logic kind, input int slot,
                                        input logic [skfs_pkg::KEY_W-1:0] key,
                                        input int first, input int last,
                                        input bit typed, input int found,
                                        input bit exact);
    stim_row_t r;
    r.kind      = kind;
    r.slot      = slot[skfs_pkg::IDX_W-1:0];
    r.key       = key;
    r.first     = first[skfs_pkg::IDX_W-1:0];
    r.last      = last[skfs_pkg::IDX_W-1:0];
    r.typed     = typed;
    r.res.found = found[skfs_pkg::FOUND_W-1:0];
    r.res.exact = exact;
    return r;
  endfunction

  // Presents one item, holds it until accepted and records what it should give.
  task automatic issue(input logic kind, input logic [skfs_pkg::IDX_W-1:0] slot,
                       input logic [skfs_pkg::KEY_W-1:0] key,
                       input logic [skfs_pkg::IDX_W-1:0] first,
                       input logic [skfs_pkg::IDX_W-1:0] last, input bit typed,
                       input lookup_t typed_res);
    int gap;
    gap = 0;
    if (!quiet) begin
      if ($urandom_range(0, 29) == 0) bursty = !bursty;
      if (bursty && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 16);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_kind        <= kind;
    in_entry_index <= slot;
    in_entry_key   <= key;
    in_first_index <= first;
    in_last_index  <= last;
    start          <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    if (kind == skfs_pkg::KIND_WRITE) begin
      key_shadow[slot] = key;
    end else if (typed) begin
      pending_lookups = {pending_lookups, typed_res};
    end else begin
      pending_lookups = {pending_lookups, floor_lookup(key, first, last)};
    end
  endtask

  // Holds the sender off until every outstanding search has answered.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_lookups.size() != 0);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_lookups.size() == 0) begin
        $error("result with no search outstanding: found_index %0d exact_match %0b",
               out_found_index, out_exact_match);
        fail_count++;
      end else begin
        want = pending_lookups.pop_front();
        if (out_found_index !== want.found) begin
          $error("found_index: expected %0d, got %0d", want.found, out_found_index);
          fail_count++;
        end
        if (out_exact_match !== want.exact) begin
          $error("exact_match: expected %0b, got %0b", want.exact, out_exact_match);
          fail_count++;
        end
      end
    end
  end

  // Ends the run if neither side moves an item for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_MAX) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t                  directed_rows [22];
    lookup_t                    none;
    logic [skfs_pkg::KEY_W-1:0] key;
    logic [skfs_pkg::KEY_W-1:0] fill_key;
    logic [skfs_pkg::KEY_W-1:0] lo_key;
    logic [skfs_pkg::KEY_W-1:0] hi_key;
    logic [skfs_pkg::KEY_W-1:0] gap_key;
    int                         slot;
    int                         first;
    int                         last;
    int                         span;
    int                         pick;
    int                         choice;

    none           = '0;
    fail_count     = 0;
    stall_cycles   = 0;
    bursty         = 1'b1;
    quiet          = 1'b0;
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_kind        <= skfs_pkg::KIND_WRITE;
    in_entry_index <= '0;
    in_entry_key   <= '0;
    in_first_index <= '0;
    in_last_index  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A small sorted table at both ends of the index range, then searches
    // over it; only written slots ever fall inside a search window.
    directed_rows = '{
      dir_row(skfs_pkg::KIND_WRITE,     0, 64'd1,         0,    0, 1'b0,    0, 1'b0),
      dir_row(skfs_pkg::KIND_WRITE,     1, 64'd10,        0,    0, 1'b0,    0, 1'b0),
      dir_row(skfs_pkg::KIND_WRITE,     2, 64'd20,        0,    0, 1'b0,    0, 1'b0),
      dir_row(skfs_pkg::KIND_WRITE,     3, KEY_MAX,       0,    0, 1'b0,    0, 1'b0),
      dir_row(skfs_pkg::KIND_WRITE,  1022, 64'd5,         0,    0, 1'b0,    0, 1'b0),
      dir_row(skfs_pkg::KIND_WRITE,  1023, KEY_MAX,       0,    0, 1'b0,    0, 1'b0),
      dir_row(skfs_pkg::KIND_SEARCH, 1023, KEY_MAX,       5,    4, 1'b1,    4, 1'b0),
      dir_row(skfs_pkg::KIND_SEARCH,    0, 64'd0,      1023,    0, 1'b1,    0, 1'b0),
      dir_row(skfs_pkg::KIND_SEARCH,    0, 64'd1,         0,    0, 1'b1,    0, 1'b1),
      dir_row(skfs_pkg::KIND_SEARCH,    0, 64'd0,         0,    3, 1'b1,   -1, 1'b0),
      dir_row(skfs_pkg::KIND_SEARCH,    0, KEY_MAX,       0,    3, 1'b1,    3, 1'b1),
      dir_row(skfs_pkg::KIND_SEARCH,    0, 64'd15,        0,    3, 1'b0,    0, 1'b0),
      dir_row(skfs_pkg::KIND_SEARCH,    0, 64'd20,        0,    3, 1'b0,    0, 1'b0),
      dir_row(skfs_pkg::KIND_SEARCH,    0, KEY_MAX - 1,   0,    3, 1'b0,    0, 1'b0),
      dir_row(skfs_pkg::KIND_SEARCH,    0, KEY_MAX,    1022, 1023, 1'b1, 1023, 1'b1),
      dir_row(skfs_pkg::KIND_SEARCH,    0, 64'd6,      1022, 1023, 1'b0,    0, 1'b0),
      dir_row(skfs_pkg::KIND_SEARCH,    0, 64'd0,      1022, 1023, 1'b0,    0, 1'b0),
      dir_row(skfs_pkg::KIND_SEARCH,    0, 64'd0,         1,    2, 1'b0,    0, 1'b0),
      dir_row(skfs_pkg::KIND_WRITE,     2, 64'd0,         0,    0, 1'b0,    0, 1'b0),
      dir_row(skfs_pkg::KIND_SEARCH,    0, 64'd0,         0,    3, 1'b0,    0, 1'b0),
      dir_row(skfs_pkg::KIND_WRITE,     2, 64'd20,        0,    0, 1'b0,    0, 1'b0),
      dir_row(skfs_pkg::KIND_SEARCH,    0, 64'd2,         3,    3, 1'b0,    0, 1'b0)
    };
    foreach (directed_rows[i]) begin
      issue(directed_rows[i].kind, directed_rows[i].slot, directed_rows[i].key,
            directed_rows[i].first, directed_rows[i].last, directed_rows[i].typed,
            directed_rows[i].res);
    end

    // Fill the whole table in ascending order. The slot number sits in the
    // top bits so the order holds, and a run of equal keys turns up now and then.
    for (int i = 0; i < DEPTH; i++) begin
      if (i > 0 && $urandom_range(0, 15) == 0) begin
        key = key_shadow[i - 1];
      end else begin
        fill_key = rand_key();
        key = {i[skfs_pkg::IDX_W-1:0],
               fill_key[skfs_pkg::KEY_W-skfs_pkg::IDX_W-1:0]};
      end
      issue(skfs_pkg::KIND_WRITE, i[skfs_pkg::IDX_W-1:0], key, rand_index(),
            rand_index(), 1'b0, none);
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      quiet  = (n >= RAND_ITEMS - QUIET_TAIL);
      if (n == 200 || n == 500) drain();
      choice = $urandom_range(0, 99);
      if (choice < 8) begin
        // Rewrite a slot with a key that keeps it between its neighbours.
        slot   = $urandom_range(0, DEPTH - 1);
        lo_key = (slot > 0) ? key_shadow[slot - 1] : '0;
        hi_key = (slot < DEPTH - 1) ? key_shadow[slot + 1] : KEY_MAX;
        gap_key = hi_key - lo_key;
        if (hi_key < lo_key) key = lo_key;
        else if (gap_key == KEY_MAX) key = rand_key();
        else key = lo_key + rand_key() % (gap_key + 1);
        issue(skfs_pkg::KIND_WRITE, slot[skfs_pkg::IDX_W-1:0], key, rand_index(),
              rand_index(), 1'b0, none);
      end else if (choice < 11) begin
        // A random key anywhere leaves the table out of order.
        issue(skfs_pkg::KIND_WRITE, rand_index(), rand_key(), rand_index(),
              rand_index(), 1'b0, none);
      end else begin
        case ($urandom_range(0, 9))
          0: begin
            first = 0;
            last  = DEPTH - 1;
          end
          1: begin
            first = $urandom_range(1, DEPTH - 1);
            last  = $urandom_range(0, first - 1);
          end
          default: begin
            first = $urandom_range(0, DEPTH - 1);
            span  = DEPTH - 1 - first;
            if ($urandom_range(0, 3) != 0 && span > 15) span = 15;
            last  = first + $urandom_range(0, span);
          end
        endcase
        if (first <= last) begin
          pick = $urandom_range(first, last);
          key  = key_shadow[pick];
        end else begin
          key = rand_key();
        end
        case ($urandom_range(0, 5))
          2: key = key + 1;
          3: key = key - 1;
          4: key = rand_key();
          5: key = $urandom_range(0, 1) ? KEY_MAX : '0;
          default: ;
        endcase
        issue(skfs_pkg::KIND_SEARCH, rand_index(), key, first[skfs_pkg::IDX_W-1:0],
              last[skfs_pkg::IDX_W-1:0], 1'b0, none);
      end
    end

    drain();
    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/skfs_pkg.sv
hw/rtl/skfs_key_ram.sv
hw/rtl/sorted_key_floor_search.sv
tb/sorted_key_floor_search_tb.sv
